// ----- hw/rtl/iff_pkg.sv -----
// ============================================================================
// iff_pkg: shared constants and helpers for the integer field formatter
// Field widths, digit counts, ASCII codes and the digit-to-character map.
// ============================================================================
package iff_pkg;

   // Fixed widths of the transaction fields.
   localparam int FIELD_W    = 7;
   localparam int BIN_W      = 64;
   localparam int CHAR_W     = 8;
   localparam int NIB_W      = 4;

   // Most digits a 64-bit value needs in decimal and in hexadecimal.
   localparam int DEC_DIGITS = 20;
   localparam int HEX_DIGITS = BIN_W / NIB_W;
   localparam int DIG_BITS   = DEC_DIGITS * NIB_W;
   localparam int SIG_W      = $clog2(DEC_DIGITS + 1);
   localparam int STEP_W     = $clog2(BIN_W);

   // Hexadecimal fields with no width given use this width.
   localparam logic [FIELD_W-1:0] HEX_DEFAULT_WIDTH = FIELD_W'(8);

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [NIB_W-1:0]  NIB_TEN     = 4'd10;

   typedef enum logic {
      MODE_DEC = 1'b0,
      MODE_HEX = 1'b1
   } mode_type;

   // Maps one digit value to its lowercase ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
      if (nib < NIB_TEN) begin
         digit_char = CHAR_ZERO + ext;
      end else begin
         digit_char = CHAR_LOWER_A + ext - {{(CHAR_W-NIB_W){1'b0}}, NIB_TEN};
      end
   endfunction

endpackage

// ----- hw/rtl/iff_if.sv -----
// ============================================================================
// iff_if: valid/ready channels of the integer field formatter
// Request channel carries the number and its format, response channel
// carries one character per transaction.
// ============================================================================
interface iff_req_if;
   import iff_pkg::*;

   logic               valid;
   logic               ready;
   logic               mode;
   logic [BIN_W-1:0]   value;
   logic [FIELD_W-1:0] field_width;
   logic               precision_given;
   logic [FIELD_W-1:0] min_digits;
   logic               zero_fill;
   logic               right_align;

   modport source (
      output valid, mode, value, field_width, precision_given, min_digits,
             zero_fill, right_align,
      input  ready
   );

   modport sink (
      input  valid, mode, value, field_width, precision_given, min_digits,
             zero_fill, right_align,
      output ready
   );
endinterface

interface iff_rsp_if;
   import iff_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last_char;

   modport source (
      output valid, out_char, last_char,
      input  ready
   );

   modport sink (
      input  valid, out_char, last_char,
      output ready
   );
endinterface

// ----- hw/rtl/integer_field_formatter_core.sv -----
// ============================================================================
// integer_field_formatter_core: 64-bit unsigned number to ASCII field
// Converts one number to decimal or lowercase hexadecimal text, pads it to
// the requested width and streams the characters out one per transaction.
// ============================================================================
// Sequence: decimal requests run the shift-add-3 conversion, then normalize, one
// setup step and one output load before the first character; hexadecimal skips
// the conversion. Characters then leave at one per cycle while the response channel is ready.
// There is a single shift-add-3 unit and a single output register, so a new request is
// taken only in idle, once the last character of the previous field has been accepted.
// Reset: synchronous, active high; returns to idle with no response pending.
module integer_field_formatter_core #(
   parameter int MAX_FIELD = 64
) (
   input  logic       clock,
   input  logic       reset,
   iff_req_if.sink    req_ch,
   iff_rsp_if.source  rsp_ch
);
   import iff_pkg::*;

   // Counter width large enough to hold any saturated width or digit count.
   localparam int CNT_W = $clog2(MAX_FIELD + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;

   // Work registers. The digit register holds BCD digits after the decimal
   // conversion or the raw nibbles of a hex value, most significant on top.
   logic [DIG_BITS-1:0]  dig_ff, dig_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SIG_W-1:0]     sig_ff, sig_in;

   // Latched format of the current request, already saturated.
   logic [CNT_W-1:0]     width_ff, width_in;
   logic [CNT_W-1:0]     prec_ff, prec_in;
   logic [CHAR_W-1:0]    pad_char_ff, pad_char_in;
   logic                 right_ff, right_in;

   // Remaining characters: padding and digits (including precision zeros).
   logic [CNT_W-1:0]     pad_cnt_ff, pad_cnt_in;
   logic [CNT_W-1:0]     dig_cnt_ff, dig_cnt_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   // Combinational helpers.
   logic [DIG_BITS-1:0]  dabble;
   logic [CNT_W-1:0]     width_sat;
   logic [CNT_W-1:0]     prec_sat;
   logic [CNT_W-1:0]     sig_ext;
   logic [CNT_W-1:0]     nd;
   logic [CNT_W-1:0]     pad_next;
   logic [CNT_W-1:0]     dig_next;
   logic [NIB_W-1:0]     top_nib;
   logic                 out_free;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_char  = char_ff;
   assign rsp_ch.last_char = last_ff;

   // Width and precision above the field limit are clamped to it.
   assign width_sat = (req_ch.field_width > FIELD_W'(MAX_FIELD)) ?
                      CNT_W'(MAX_FIELD) : CNT_W'(req_ch.field_width);
   assign prec_sat  = (req_ch.min_digits > FIELD_W'(MAX_FIELD)) ?
                      CNT_W'(MAX_FIELD) : CNT_W'(req_ch.min_digits);

   assign sig_ext  = CNT_W'(sig_ff);
   assign nd       = (sig_ext > prec_ff) ? sig_ext : prec_ff;
   assign top_nib  = dig_ff[DIG_BITS-1 -: NIB_W];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Shift-add-3 correction: every BCD digit of 5 or more gets 3 added before
   // the next left shift, so the digits stay decimal as the binary shifts in.
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (dig_ff[i*NIB_W +: NIB_W] >= 4'd5) begin
            dabble[i*NIB_W +: NIB_W] = dig_ff[i*NIB_W +: NIB_W] + 4'd3;
         end else begin
            dabble[i*NIB_W +: NIB_W] = dig_ff[i*NIB_W +: NIB_W];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      sig_in       = sig_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      pad_char_in  = pad_char_ff;
      right_in     = right_ff;
      pad_cnt_in   = pad_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      pad_next     = pad_cnt_ff;
      dig_next     = dig_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (mode_type'(req_ch.mode) == MODE_HEX) begin
                  // Hex ignores precision, fill and alignment: at least one
                  // digit, zero padding before the digits.
                  width_in    = (width_sat == '0) ? CNT_W'(HEX_DEFAULT_WIDTH) : width_sat;
                  prec_in     = CNT_W'(1);
                  pad_char_in = CHAR_ZERO;
                  right_in    = 1'b1;
                  dig_in      = {req_ch.value, {(DIG_BITS-BIN_W){1'b0}}};
                  sig_in      = SIG_W'(HEX_DIGITS);
                  state_in    = ST_NORM;
               end else begin
                  width_in    = width_sat;
                  prec_in     = req_ch.precision_given ? prec_sat : CNT_W'(1);
                  pad_char_in = req_ch.zero_fill ? CHAR_ZERO : CHAR_SPACE;
                  right_in    = req_ch.right_align;
                  dig_in      = '0;
                  bin_in      = req_ch.value;
                  step_in     = '0;
                  state_in    = ST_CONVERT;
               end
            end
         end

         ST_CONVERT: begin
            // One binary bit enters the BCD register per cycle.
            dig_in  = {dabble[DIG_BITS-2:0], bin_ff[BIN_W-1]};
            bin_in  = {bin_ff[BIN_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == {STEP_W{1'b1}}) begin
               sig_in   = SIG_W'(DEC_DIGITS);
               state_in = ST_NORM;
            end
         end

         ST_NORM: begin
            // Strip leading zero digits; sig counts the significant ones left.
            // A zero value ends with no significant digits at all.
            if (sig_ff != '0 && top_nib == '0) begin
               dig_in = {dig_ff[DIG_BITS-NIB_W-1:0], {NIB_W{1'b0}}};
               sig_in = sig_ff - 1'b1;
            end else begin
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            dig_cnt_in = nd;
            pad_cnt_in = (width_ff > nd) ? (width_ff - nd) : '0;
            state_in   = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               if (pad_cnt_ff == '0 && dig_cnt_ff == '0) begin
                  // Field finished, or empty (zero with precision zero and no
                  // width): nothing more to send.
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (right_ff && pad_cnt_ff != '0) begin
                     char_in  = pad_char_ff;
                     pad_next = pad_cnt_ff - 1'b1;
                  end else if (dig_cnt_ff != '0) begin
                     if (dig_cnt_ff > sig_ext) begin
                        // Leading zeros demanded by the precision.
                        char_in = CHAR_ZERO;
                     end else begin
                        char_in = digit_char(top_nib);
                        dig_in  = {dig_ff[DIG_BITS-NIB_W-1:0], {NIB_W{1'b0}}};
                        sig_in  = sig_ff - 1'b1;
                     end
                     dig_next = dig_cnt_ff - 1'b1;
                  end else begin
                     char_in  = pad_char_ff;
                     pad_next = pad_cnt_ff - 1'b1;
                  end
                  pad_cnt_in = pad_next;
                  dig_cnt_in = dig_next;
                  last_in    = (pad_next == '0) && (dig_next == '0);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff      <= dig_in;
      bin_ff      <= bin_in;
      step_ff     <= step_in;
      sig_ff      <= sig_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      pad_char_ff <= pad_char_in;
      right_ff    <= right_in;
      pad_cnt_ff  <= pad_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

   // A pending character always means a request is still in progress.
   a_busy_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ch.ready)
      else $error("request taken while a character is pending");

   // Once the final character of a field is taken, no further character follows.
   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_char) |=> !rsp_ch.valid)
      else $error("character sent after the last one of a field");

   // The digit count still to send always covers the unsent significant digits.
   a_digits_cover_sig: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (dig_cnt_ff >= sig_ext))
      else $error("significant digits would be dropped");

endmodule
